@@ rtl/vda_pkg.sv @@
// Shared types, constants and index arithmetic for the voxel dose accumulator.
package vda_pkg;

    localparam int X_BINS = 64;
    localparam int Y_BINS = 64;
    localparam int Z_BINS = 64;

    localparam int X_W = $clog2(X_BINS);
    localparam int Y_W = $clog2(Y_BINS);
    localparam int Z_W = $clog2(Z_BINS);

    localparam int STORE_DEPTH = 262144;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int POS_W   = 24;
    localparam int FRAC_W  = 8;
    localparam int SHIFT_W = 14;
    localparam int AXIS_W  = 26;
    localparam int DOSE_W  = 16;
    localparam int ACC_W   = 32;
    localparam int LIN_W   = 32;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [AXIS_W-1:0]  X_LIM     = AXIS_W'(X_BINS);
    localparam logic [AXIS_W-1:0]  Y_LIM     = AXIS_W'(Y_BINS);
    localparam logic [AXIS_W-1:0]  Z_LIM     = AXIS_W'(Z_BINS);
    localparam logic [LIN_W-1:0]   X_MUL     = LIN_W'(X_BINS);
    localparam logic [LIN_W-1:0]   YX_MUL    = LIN_W'(Y_BINS * X_BINS);
    localparam logic [LIN_W-1:0]   GRID_LIM  = LIN_W'(X_BINS * Y_BINS * Z_BINS);
    localparam logic [LIN_W-1:0]   DEPTH_LIM = LIN_W'(STORE_DEPTH);
    localparam logic [STORE_AW-1:0] LAST_ADDR = STORE_AW'(STORE_DEPTH - 1);
    localparam logic [ACC_W-1:0]   ACC_MAX   = '1;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(32);

    localparam logic FUNC_DEPOSIT = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    typedef enum logic [1:0] {
        REG_X_SHIFT = 2'd0,
        REG_Y_SHIFT = 2'd1,
        REG_Z_SHIFT = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_AXIS,
        ST_LINEAR,
        ST_READ,
        ST_UPDATE
    } state_t;

    // floor(-pos / 256) + shift: arithmetic shift of the negated value floors it
    function automatic logic [AXIS_W-1:0] axis_index(input logic [POS_W-1:0] pos,
                                                     input logic [SHIFT_W-1:0] shift);
        logic [POS_W:0] neg;
        neg = -{pos[POS_W-1], pos};
        return {{(AXIS_W - (POS_W + 1 - FRAC_W)){neg[POS_W]}}, neg[POS_W:FRAC_W]}
             + {{(AXIS_W - SHIFT_W){shift[SHIFT_W-1]}}, shift};
    endfunction

endpackage

@@ rtl/vda_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module vda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/voxel_dose_accumulator_top.sv @@
// Voxel dose accumulator: 3-D dose histogram with read-modify-write on one RAM.
//
// Input stream (s_*): one transaction per deposit or read. s_tuser is the function
// (deposit or read); s_tdata carries the positions, dose and read index.
// Output stream (m_*): exactly one result transaction per input transaction, in order.
// Deposits negate, floor and shift each coordinate, then add the dose into the
// addressed voxel, saturating at the 32-bit maximum; out-of-grid deposits change
// nothing and return in_range = 0. Reads return the voxel at a linear index.
// The voxel RAM is read, updated and written back for one transaction before the next
// is taken (index stage, linear address stage, registered RAM read, update and
// write-back).
// The result sits in an output register, so the next transaction is accepted while
// it waits; when the receiver stalls, the following update holds until it drains.
// Reset: shift registers return to 32, then a clearing pass writes zero to all
// 262144 voxels, one per cycle; s_tready stays low until the pass is done.
// APB writes and reads are served at all times; pready is tied high.
module voxel_dose_accumulator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [vda_pkg::APB_AW-1:0]       paddr,
    input  logic [vda_pkg::APB_DW-1:0]       pwdata,
    output logic [vda_pkg::APB_DW-1:0]       prdata,
    output logic                             pready,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x[23:0], pos_y[47:24], pos_z[71:48], dose_amount[87:72], read_index[105:88]
    input  logic [vda_pkg::S_TDATA_W-1:0]    s_tdata,
    // func[0]
    input  logic                             s_tuser,
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // voxel_index[17:0], voxel_total[49:18]
    output logic [vda_pkg::M_TDATA_W-1:0]    m_tdata,
    // in_range[0], saturated[1]
    output logic [vda_pkg::M_TUSER_W-1:0]    m_tuser
);

    // configuration
    logic [vda_pkg::SHIFT_W-1:0] x_shift_reg, y_shift_reg, z_shift_reg;
    logic                        cfg_wr;
    vda_pkg::reg_idx_t           cfg_idx;

    // control
    vda_pkg::state_t              state_reg, state_next;
    logic [vda_pkg::STORE_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic                         out_valid_reg, out_valid_next;

    // item payload
    logic                         func_reg;
    logic [vda_pkg::POS_W-1:0]    pos_x_reg, pos_y_reg, pos_z_reg;
    logic [vda_pkg::DOSE_W-1:0]   dose_reg;
    logic [vda_pkg::STORE_AW-1:0] rd_idx_reg;
    logic [vda_pkg::X_W-1:0]      ax_i_reg;
    logic [vda_pkg::Y_W-1:0]      ax_j_reg;
    logic [vda_pkg::Z_W-1:0]      ax_k_reg;
    logic                         ax_ok_reg;
    logic [vda_pkg::STORE_AW-1:0] lin_reg;
    logic                         ok_reg;
    logic [vda_pkg::M_TDATA_W-1:0] out_tdata_reg;
    logic [vda_pkg::M_TUSER_W-1:0] out_tuser_reg;

    // datapath
    logic [vda_pkg::AXIS_W-1:0]   ix, iy, iz;
    logic                         ix_ok, iy_ok, iz_ok;
    logic [vda_pkg::LIN_W-1:0]    lin_full;
    logic [vda_pkg::LIN_W-1:0]    rd_idx_wide;
    logic [vda_pkg::ACC_W:0]      sum;
    logic                         sat;
    logic [vda_pkg::ACC_W-1:0]    total;
    logic                         accept;
    logic                         update_done;

    // RAM port
    logic                         ram_we;
    logic [vda_pkg::STORE_AW-1:0] ram_waddr;
    logic [vda_pkg::ACC_W-1:0]    ram_wdata;
    logic [vda_pkg::ACC_W-1:0]    ram_rdata;

    vda_ram #(
        .WIDTH (vda_pkg::ACC_W),
        .DEPTH (vda_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (lin_reg),
        .rdata (ram_rdata)
    );

    // ---------------- APB ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = vda_pkg::reg_idx_t'(paddr[vda_pkg::APB_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_shift_reg <= vda_pkg::SHIFT_RESET;
            y_shift_reg <= vda_pkg::SHIFT_RESET;
            z_shift_reg <= vda_pkg::SHIFT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                vda_pkg::REG_X_SHIFT: x_shift_reg <= pwdata[vda_pkg::SHIFT_W-1:0];
                vda_pkg::REG_Y_SHIFT: y_shift_reg <= pwdata[vda_pkg::SHIFT_W-1:0];
                vda_pkg::REG_Z_SHIFT: z_shift_reg <= pwdata[vda_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            vda_pkg::REG_X_SHIFT:
                prdata = {{(vda_pkg::APB_DW - vda_pkg::SHIFT_W){x_shift_reg[vda_pkg::SHIFT_W-1]}},
                          x_shift_reg};
            vda_pkg::REG_Y_SHIFT:
                prdata = {{(vda_pkg::APB_DW - vda_pkg::SHIFT_W){y_shift_reg[vda_pkg::SHIFT_W-1]}},
                          y_shift_reg};
            vda_pkg::REG_Z_SHIFT:
                prdata = {{(vda_pkg::APB_DW - vda_pkg::SHIFT_W){z_shift_reg[vda_pkg::SHIFT_W-1]}},
                          z_shift_reg};
            default:
                prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    assign ix = vda_pkg::axis_index(pos_x_reg, x_shift_reg);
    assign iy = vda_pkg::axis_index(pos_y_reg, y_shift_reg);
    assign iz = vda_pkg::axis_index(pos_z_reg, z_shift_reg);

    assign ix_ok = !ix[vda_pkg::AXIS_W-1] && (ix < vda_pkg::X_LIM);
    assign iy_ok = !iy[vda_pkg::AXIS_W-1] && (iy < vda_pkg::Y_LIM);
    assign iz_ok = !iz[vda_pkg::AXIS_W-1] && (iz < vda_pkg::Z_LIM);

    // slice-major linear address
    assign lin_full = {{(vda_pkg::LIN_W - vda_pkg::Z_W){1'b0}}, ax_k_reg} * vda_pkg::YX_MUL
                    + {{(vda_pkg::LIN_W - vda_pkg::Y_W){1'b0}}, ax_j_reg} * vda_pkg::X_MUL
                    + {{(vda_pkg::LIN_W - vda_pkg::X_W){1'b0}}, ax_i_reg};

    assign rd_idx_wide = {{(vda_pkg::LIN_W - vda_pkg::STORE_AW){1'b0}}, rd_idx_reg};

    assign sum   = {1'b0, ram_rdata} + {{(vda_pkg::ACC_W + 1 - vda_pkg::DOSE_W){1'b0}}, dose_reg};
    assign sat   = (func_reg == vda_pkg::FUNC_DEPOSIT) && ok_reg && sum[vda_pkg::ACC_W];

    always_comb
    begin
        if (!ok_reg)
        begin
            total = '0;
        end
        else if (func_reg == vda_pkg::FUNC_READ)
        begin
            total = ram_rdata;
        end
        else if (sum[vda_pkg::ACC_W])
        begin
            total = vda_pkg::ACC_MAX;
        end
        else
        begin
            total = sum[vda_pkg::ACC_W-1:0];
        end
    end

    // ---------------- control ----------------
    assign s_tready    = (state_reg == vda_pkg::ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign update_done = (state_reg == vda_pkg::ST_UPDATE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = lin_reg;
        ram_wdata      = total;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            vda_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == vda_pkg::LAST_ADDR)
                begin
                    state_next = vda_pkg::ST_IDLE;
                end
            end
            vda_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = vda_pkg::ST_AXIS;
                end
            end
            vda_pkg::ST_AXIS:
            begin
                state_next = vda_pkg::ST_LINEAR;
            end
            vda_pkg::ST_LINEAR:
            begin
                state_next = vda_pkg::ST_READ;
            end
            vda_pkg::ST_READ:
            begin
                state_next = vda_pkg::ST_UPDATE;
            end
            vda_pkg::ST_UPDATE:
            begin
                // hold until the output register is free
                if (update_done)
                begin
                    ram_we         = ok_reg && (func_reg == vda_pkg::FUNC_DEPOSIT);
                    out_valid_next = 1'b1;
                    state_next     = vda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vda_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= s_tuser;
            pos_x_reg  <= s_tdata[23:0];
            pos_y_reg  <= s_tdata[47:24];
            pos_z_reg  <= s_tdata[71:48];
            dose_reg   <= s_tdata[87:72];
            rd_idx_reg <= s_tdata[105:88];
        end

        if (state_reg == vda_pkg::ST_AXIS)
        begin
            ax_i_reg  <= ix[vda_pkg::X_W-1:0];
            ax_j_reg  <= iy[vda_pkg::Y_W-1:0];
            ax_k_reg  <= iz[vda_pkg::Z_W-1:0];
            ax_ok_reg <= ix_ok && iy_ok && iz_ok;
        end

        if (state_reg == vda_pkg::ST_LINEAR)
        begin
            if (func_reg == vda_pkg::FUNC_READ)
            begin
                lin_reg <= rd_idx_reg;
                ok_reg  <= (rd_idx_wide < vda_pkg::GRID_LIM);
            end
            else
            begin
                lin_reg <= lin_full[vda_pkg::STORE_AW-1:0];
                ok_reg  <= ax_ok_reg && (lin_full < vda_pkg::DEPTH_LIM);
            end
        end

        if (update_done)
        begin
            out_tdata_reg <= {{(vda_pkg::M_TDATA_W - vda_pkg::ACC_W - vda_pkg::STORE_AW){1'b0}},
                              total, (ok_reg ? lin_reg : {vda_pkg::STORE_AW{1'b0}})};
            out_tuser_reg <= {sat, ok_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

endmodule
